// ===== hdl/pfds_pkg.sv =====
`default_nettype none

package pfds_pkg;

   localparam int PAGES_DEF   = 8;
   localparam int COLUMNS_DEF = 128;
   localparam int Q_DEPTH     = 4;

   localparam int OP_W     = 2;
   localparam int COLX_W   = 7;
   localparam int ROW_W    = 6;
   localparam int VAL_W    = 8;
   localparam int PSEL_W   = 3;
   localparam int DATA_W   = 64;
   localparam int CNT_W    = 4;
   localparam int BYTE_W   = 8;

   localparam logic [VAL_W-1:0] FILL_SET = 8'hFF;

   typedef enum logic [OP_W-1:0] {
      OP_PAINT  = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_RENDER = 2'd2
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [COLX_W-1:0]   column;
      logic [ROW_W-1:0]    row;
      logic [VAL_W-1:0]    value;
      logic [PSEL_W-1:0]   page;
   } cmd_type;

   typedef struct packed {
      logic    empty;
      cmd_type cmd;
   } qhead_type;

endpackage

`default_nettype wire

// ===== hdl/pfds_front.sv =====
`default_nettype none

module pfds_front
   import pfds_pkg::*;
#(
   parameter int PAGES   = PAGES_DEF,
   parameter int COLUMNS = COLUMNS_DEF
) (
   input  wire logic              start,
   input  wire logic              busy,
   input  wire logic [OP_W-1:0]   req_opcode,
   input  wire logic [COLX_W-1:0] req_column_x,
   input  wire logic [ROW_W-1:0]  req_row_y,
   input  wire logic [VAL_W-1:0]  req_value,
   input  wire logic [PSEL_W-1:0] req_page_select,
   output logic                   push,
   output cmd_type                push_cmd
);

   logic keep;

   always_comb begin
      push_cmd.op     = op_type'(req_opcode);
      push_cmd.column = req_column_x;
      push_cmd.row    = req_row_y;
      push_cmd.value  = req_value;
      push_cmd.page   = req_page_select;
      unique case (req_opcode)
         OP_PAINT: begin
            keep = (32'(req_row_y[ROW_W-1:3]) < PAGES) && (32'(req_column_x) < COLUMNS);
         end
         OP_CLEAR: begin
            keep = 1'b1;
         end
         OP_RENDER: begin
            keep = 32'(req_page_select) < PAGES;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      push = start && !busy && keep;
   end

endmodule

`default_nettype wire

// ===== hdl/pfds_queue.sv =====
`default_nettype none

module pfds_queue
   import pfds_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output qhead_type    head,
   output logic         full
);

   localparam int QA_W = $clog2(Q_DEPTH);

   cmd_type          q_mem [Q_DEPTH];
   logic [QA_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QA_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QA_W:0]    cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QA_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QA_W'(1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + (QA_W+1)'(1);
         2'b01:   cnt_in = cnt_ff - (QA_W+1)'(1);
         default: cnt_in = cnt_ff;
      endcase
      head.empty = cnt_ff == '0;
      head.cmd   = q_mem[rd_ptr_ff];
      full       = cnt_ff == (QA_W+1)'(Q_DEPTH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/pfds_engine.sv =====
`default_nettype none

module pfds_engine
   import pfds_pkg::*;
#(
   parameter int PAGES   = PAGES_DEF,
   parameter int COLUMNS = COLUMNS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire qhead_type          head,
   output logic                    pop,
   output logic                    rsp_valid,
   output logic                    rsp_kind,
   output logic [PSEL_W-1:0]       rsp_page_index,
   output logic [COLX_W-1:0]       rsp_span_start,
   output logic [COLX_W-1:0]       rsp_span_end,
   output logic [DATA_W-1:0]       rsp_data_word,
   output logic [CNT_W-1:0]        rsp_byte_count,
   output logic                    rsp_last
);

   localparam int COL_W     = $clog2(COLUMNS);
   localparam int PG_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int ADDR_W    = PG_W + COL_W;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam int LANES     = DATA_W / BYTE_W;
   localparam int LANE_W    = $clog2(LANES);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
   localparam logic [PG_W-1:0]   LAST_PG   = PG_W'(PAGES - 1);
   localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(LANES - 1);

   typedef enum logic [8:0] {
      ST_INIT      = 9'b000000001,
      ST_IDLE      = 9'b000000010,
      ST_PAINT_RD  = 9'b000000100,
      ST_PAINT_WR  = 9'b000001000,
      ST_CLEAR     = 9'b000010000,
      ST_SCAN      = 9'b000100000,
      ST_SCAN_TAIL = 9'b001000000,
      ST_HEADER    = 9'b010000000,
      ST_COPY      = 9'b100000000
   } state_type;

   state_type           state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [PG_W-1:0]     pg_ff, pg_in;
   logic [COL_W-1:0]    first_ff, first_in;
   logic [COL_W-1:0]    last_ff, last_in;
   logic                found_ff, found_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [COL_W-1:0]    rd_col_ff, rd_col_in;
   logic                issue_done_ff, issue_done_in;
   logic [LANE_W-1:0]   lane_ff, lane_in;
   logic [DATA_W-1:0]   acc_ff, acc_in;

   logic                out_vld_ff, out_vld_in;
   logic                out_kind_ff, out_kind_in;
   logic [DATA_W-1:0]   out_word_ff, out_word_in;
   logic [CNT_W-1:0]    out_cnt_ff, out_cnt_in;
   logic                out_last_ff, out_last_in;
   logic [PG_W-1:0]     out_pg_ff, out_pg_in;
   logic [COL_W-1:0]    out_first_ff, out_first_in;
   logic [COL_W-1:0]    out_lastc_ff, out_lastc_in;

   logic [BYTE_W-1:0]   frame_mem [MEM_DEPTH];
   logic [BYTE_W-1:0]   sent_mem  [MEM_DEPTH];
   logic [BYTE_W-1:0]   fr_rdata_ff;
   logic [BYTE_W-1:0]   st_rdata_ff;

   logic                fr_we, st_we;
   logic [ADDR_W-1:0]   fr_waddr, st_waddr, fr_raddr, st_raddr;
   logic [BYTE_W-1:0]   fr_wdata, st_wdata;

   logic [PG_W-1:0]     rnd_pg;
   logic [ADDR_W-1:0]   pnt_addr;
   logic [ADDR_W-1:0]   scan_addr;
   logic [BYTE_W-1:0]   pnt_mask;
   logic                diff;
   logic                end_now;
   logic [DATA_W-1:0]   word_now;

   always_comb begin
      rnd_pg    = PG_W'(cmd_ff.page);
      pnt_addr  = {PG_W'(cmd_ff.row[ROW_W-1:3]), COL_W'(cmd_ff.column)};
      scan_addr = {rnd_pg, col_ff};
      pnt_mask  = BYTE_W'(1) << cmd_ff.row[2:0];
      diff      = rd_vld_ff && (fr_rdata_ff != st_rdata_ff);
      end_now   = rd_col_ff == last_ff;
      for (int i = 0; i < LANES; i++) begin
         word_now[i*BYTE_W +: BYTE_W] = (lane_ff == LANE_W'(i)) ? fr_rdata_ff
                                                                 : acc_ff[i*BYTE_W +: BYTE_W];
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      col_in        = col_ff;
      pg_in         = pg_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      found_in      = found_ff;
      rd_vld_in     = 1'b0;
      rd_col_in     = col_ff;
      issue_done_in = issue_done_ff;
      lane_in       = lane_ff;
      acc_in        = acc_ff;
      pop           = 1'b0;

      out_vld_in   = 1'b0;
      out_kind_in  = out_kind_ff;
      out_word_in  = out_word_ff;
      out_cnt_in   = out_cnt_ff;
      out_last_in  = out_last_ff;
      out_pg_in    = rnd_pg;
      out_first_in = first_ff;
      out_lastc_in = last_ff;

      fr_we    = 1'b0;
      fr_waddr = {pg_ff, col_ff};
      fr_wdata = '0;
      fr_raddr = scan_addr;
      st_we    = 1'b0;
      st_waddr = {pg_ff, col_ff};
      st_wdata = '0;
      st_raddr = scan_addr;

      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            fr_we    = 1'b1;
            fr_wdata = (state_ff == ST_CLEAR) ? cmd_ff.value : '0;
            st_we    = state_ff == ST_INIT;
            col_in   = col_ff + COL_W'(1);
            if (col_ff == LAST_COL) begin
               col_in = '0;
               pg_in  = pg_ff + PG_W'(1);
               if (pg_ff == LAST_PG) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            if (!head.empty) begin
               pop      = 1'b1;
               cmd_in   = head.cmd;
               col_in   = '0;
               pg_in    = '0;
               found_in = 1'b0;
               unique case (head.cmd.op)
                  OP_PAINT:  state_in = ST_PAINT_RD;
                  OP_CLEAR:  state_in = ST_CLEAR;
                  OP_RENDER: state_in = ST_SCAN;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_PAINT_RD: begin
            fr_raddr = pnt_addr;
            state_in = ST_PAINT_WR;
         end
         ST_PAINT_WR: begin
            fr_we    = 1'b1;
            fr_waddr = pnt_addr;
            fr_wdata = (cmd_ff.value == FILL_SET) ? (fr_rdata_ff | pnt_mask)
                                                  : (fr_rdata_ff & ~pnt_mask);
            state_in = ST_IDLE;
         end
         ST_SCAN, ST_SCAN_TAIL: begin
            if (diff) begin
               if (!found_ff) begin
                  first_in = rd_col_ff;
               end
               last_in  = rd_col_ff;
               found_in = 1'b1;
            end
            if (state_ff == ST_SCAN) begin
               rd_vld_in = 1'b1;
               col_in    = col_ff + COL_W'(1);
               if (col_ff == LAST_COL) begin
                  state_in = ST_SCAN_TAIL;
               end
            end else begin
               state_in = ST_HEADER;
            end
         end
         ST_HEADER: begin
            if (found_ff) begin
               out_vld_in    = 1'b1;
               out_kind_in   = 1'b0;
               out_word_in   = '0;
               out_cnt_in    = '0;
               out_last_in   = 1'b0;
               col_in        = first_ff;
               issue_done_in = 1'b0;
               lane_in       = '0;
               acc_in        = '0;
               state_in      = ST_COPY;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_COPY: begin
            if (!issue_done_ff) begin
               rd_vld_in = 1'b1;
               col_in    = col_ff + COL_W'(1);
               if (col_ff == last_ff) begin
                  issue_done_in = 1'b1;
               end
            end
            if (rd_vld_ff) begin
               st_we    = 1'b1;
               st_waddr = {rnd_pg, rd_col_ff};
               st_wdata = fr_rdata_ff;
               if (lane_ff == LAST_LANE || end_now) begin
                  out_vld_in  = 1'b1;
                  out_kind_in = 1'b1;
                  out_word_in = word_now;
                  out_cnt_in  = CNT_W'(lane_ff) + CNT_W'(1);
                  out_last_in = end_now;
                  acc_in      = '0;
                  lane_in     = '0;
               end else begin
                  acc_in  = word_now;
                  lane_in = lane_ff + LANE_W'(1);
               end
               if (end_now) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_INIT;
         col_ff     <= '0;
         pg_ff      <= '0;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         col_ff     <= col_in;
         pg_ff      <= pg_in;
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      found_ff      <= found_in;
      rd_col_ff     <= rd_col_in;
      issue_done_ff <= issue_done_in;
      lane_ff       <= lane_in;
      acc_ff        <= acc_in;
      out_kind_ff   <= out_kind_in;
      out_word_ff   <= out_word_in;
      out_cnt_ff    <= out_cnt_in;
      out_last_ff   <= out_last_in;
      out_pg_ff     <= out_pg_in;
      out_first_ff  <= out_first_in;
      out_lastc_ff  <= out_lastc_in;
   end

   always_ff @(posedge clock) begin
      if (fr_we) begin
         frame_mem[fr_waddr] <= fr_wdata;
      end
      fr_rdata_ff <= frame_mem[fr_raddr];
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         sent_mem[st_waddr] <= st_wdata;
      end
      st_rdata_ff <= sent_mem[st_raddr];
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_kind       = out_kind_ff;
   assign rsp_page_index = PSEL_W'(out_pg_ff);
   assign rsp_span_start = COLX_W'(out_first_ff);
   assign rsp_span_end   = COLX_W'(out_lastc_ff);
   assign rsp_data_word  = out_word_ff;
   assign rsp_byte_count = out_cnt_ff;
   assign rsp_last       = out_last_ff;

endmodule

`default_nettype wire

// ===== hdl/page_framebuffer_dirty_span.sv =====
// Paint reads and then rewrites one byte; clear sweeps every byte of the frame store; render
// scans the page, gives a header if any column differs, then span bytes stream at one column per cycle.
// Throughput: one transaction at a time in the back end, bound by the frame memory port;
// a 4-deep command queue lets start be taken while a render or clear runs.
// Reset: synchronous; both stores are zeroed by a sweep over every byte, commands queue.
// The receiver cannot stall: each result is shown for one cycle on rsp_valid.
`default_nettype none

module page_framebuffer_dirty_span
   import pfds_pkg::*;
#(
   parameter int PAGES   = PAGES_DEF,
   parameter int COLUMNS = COLUMNS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [OP_W-1:0]   req_opcode,
   input  wire logic [COLX_W-1:0] req_column_x,
   input  wire logic [ROW_W-1:0]  req_row_y,
   input  wire logic [VAL_W-1:0]  req_value,
   input  wire logic [PSEL_W-1:0] req_page_select,
   output logic                   rsp_valid,
   output logic                   rsp_kind,
   output logic [PSEL_W-1:0]      rsp_page_index,
   output logic [COLX_W-1:0]      rsp_span_start,
   output logic [COLX_W-1:0]      rsp_span_end,
   output logic [DATA_W-1:0]      rsp_data_word,
   output logic [CNT_W-1:0]       rsp_byte_count,
   output logic                   rsp_last
);

   logic      push;
   cmd_type   push_cmd;
   logic      pop;
   qhead_type head;

   pfds_front #(
      .PAGES   (PAGES),
      .COLUMNS (COLUMNS)
   ) u_front (
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_column_x    (req_column_x),
      .req_row_y       (req_row_y),
      .req_value       (req_value),
      .req_page_select (req_page_select),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   pfds_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .full     (busy)
   );

   pfds_engine #(
      .PAGES   (PAGES),
      .COLUMNS (COLUMNS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_kind       (rsp_kind),
      .rsp_page_index (rsp_page_index),
      .rsp_span_start (rsp_span_start),
      .rsp_span_end   (rsp_span_end),
      .rsp_data_word  (rsp_data_word),
      .rsp_byte_count (rsp_byte_count),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// ===== hdl/pfds_checker.sv =====
`default_nettype none

module pfds_checker
   import pfds_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_kind,
   input wire logic [COLX_W-1:0] rsp_span_start,
   input wire logic [COLX_W-1:0] rsp_span_end,
   input wire logic [DATA_W-1:0] rsp_data_word,
   input wire logic [CNT_W-1:0]  rsp_byte_count,
   input wire logic              rsp_last
);

   a_header_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> rsp_byte_count == '0 && rsp_data_word == '0 && !rsp_last)
      else $error("span header carries data");

   a_data_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_byte_count != '0 && rsp_byte_count <= CNT_W'(8)
                                && rsp_span_start <= rsp_span_end)
      else $error("bad data item count or span");

   a_full_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind && !rsp_last |-> rsp_byte_count == CNT_W'(8))
      else $error("short data item before end of span");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result right after final item");

endmodule

bind page_framebuffer_dirty_span pfds_checker u_pfds_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_kind       (rsp_kind),
   .rsp_span_start (rsp_span_start),
   .rsp_span_end   (rsp_span_end),
   .rsp_data_word  (rsp_data_word),
   .rsp_byte_count (rsp_byte_count),
   .rsp_last       (rsp_last)
);

`default_nettype wire

// ===== verif/page_framebuffer_dirty_span_tb.sv =====
`timescale 1ns / 100ps

module page_framebuffer_dirty_span_tb;
   import pfds_pkg::*;

   localparam int PAGES        = PAGES_DEF;
   localparam int COLUMNS      = COLUMNS_DEF;
   localparam int STORE_BYTES  = PAGES * COLUMNS;
   localparam int RANDOM_ITEMS = 500;
   localparam int DRAIN_CYCLES = 6 * (STORE_BYTES + COLUMNS + 8);
   localparam int CYCLE_LIMIT  = 3_000_000;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic            KIND_HEADER = 1'b0;
   localparam logic            KIND_DATA   = 1'b1;

   typedef struct {
      logic                kind;
      logic [PSEL_W-1:0]   page;
      logic [COLX_W-1:0]   first_col;
      logic [COLX_W-1:0]   last_col;
      logic [DATA_W-1:0]   data;
      logic [CNT_W-1:0]    count;
      logic                last;
   } span_item_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [OP_W-1:0]     req_opcode;
   logic [COLX_W-1:0]   req_column_x;
   logic [ROW_W-1:0]    req_row_y;
   logic [VAL_W-1:0]    req_value;
   logic [PSEL_W-1:0]   req_page_select;
   logic                rsp_valid;
   logic                rsp_kind;
   logic [PSEL_W-1:0]   rsp_page_index;
   logic [COLX_W-1:0]   rsp_span_start;
   logic [COLX_W-1:0]   rsp_span_end;
   logic [DATA_W-1:0]   rsp_data_word;
   logic [CNT_W-1:0]    rsp_byte_count;
   logic                rsp_last;

   logic [BYTE_W-1:0]   frame_mem [STORE_BYTES];
   logic [BYTE_W-1:0]   shown_mem [STORE_BYTES];
   span_item_type       pending_spans [$];
   int                  errors;
   int                  items_sent;
   int                  cycle_count;
   bit                  gap_off;

   page_framebuffer_dirty_span u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_column_x    (req_column_x),
      .req_row_y       (req_row_y),
      .req_value       (req_value),
      .req_page_select (req_page_select),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_page_index  (rsp_page_index),
      .rsp_span_start  (rsp_span_start),
      .rsp_span_end    (rsp_span_end),
      .rsp_data_word   (rsp_data_word),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_last        (rsp_last)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still pending", $time, pending_spans.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // dirty-span scan of one page against what was last shown
   function automatic void predict_render(input logic [PSEL_W-1:0] psel);
      int             base;
      int             first_x;
      int             last_x;
      int             x;
      int             cnt;
      bit             found;
      span_item_type  item;

      found   = 0;
      first_x = 0;
      last_x  = 0;
      if (psel >= PAGES) return;
      base = psel * COLUMNS;
      for (x = 0; x < COLUMNS; x++) begin
         if (frame_mem[base + x] != shown_mem[base + x]) begin
            if (!found) first_x = x;
            last_x = x;
            found  = 1;
         end
      end
      if (!found) return;

      item.kind      = KIND_HEADER;
      item.page      = psel;
      item.first_col = first_x[COLX_W-1:0];
      item.last_col  = last_x[COLX_W-1:0];
      item.data      = '0;
      item.count     = '0;
      item.last      = 1'b0;
      pending_spans.push_back(item);

      x = first_x;
      while (x <= last_x) begin
         item.kind = KIND_DATA;
         item.data = '0;
         cnt = 0;
         while (cnt < 8 && x <= last_x) begin
            item.data[cnt*BYTE_W +: BYTE_W] = frame_mem[base + x];
            cnt++;
            x++;
         end
         item.count = cnt[CNT_W-1:0];
         item.last  = (x > last_x);
         pending_spans.push_back(item);
      end
      for (x = 0; x < COLUMNS; x++) shown_mem[base + x] = frame_mem[base + x];
   endfunction

   function automatic void apply_frame_cmd(input logic [OP_W-1:0]   opc,
                                           input logic [COLX_W-1:0] col,
                                           input logic [ROW_W-1:0]  row,
                                           input logic [VAL_W-1:0]  val,
                                           input logic [PSEL_W-1:0] psel);
      int page;
      int idx;

      page = row / 8;
      case (opc)
         OP_PAINT: begin
            if (page < PAGES && col < COLUMNS) begin
               idx = page * COLUMNS + col;
               frame_mem[idx][row % 8] = (val == FILL_SET);
            end
         end
         OP_CLEAR: begin
            foreach (frame_mem[i]) frame_mem[i] = val;
         end
         OP_RENDER: predict_render(psel);
         default: ;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;

      if (gap_off) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   task automatic send_cmd(input logic [OP_W-1:0]   opc,
                           input logic [COLX_W-1:0] col,
                           input logic [ROW_W-1:0]  row,
                           input logic [VAL_W-1:0]  val,
                           input logic [PSEL_W-1:0] psel);
      int gap;

      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_opcode      <= opc;
      req_column_x    <= col;
      req_row_y       <= row;
      req_value       <= val;
      req_page_select <= psel;
      @(posedge clock);
      while (busy) @(posedge clock);
      apply_frame_cmd(opc, col, row, val, psel);
      items_sent++;
   endtask

   function automatic int field_diff(input string name, input logic [DATA_W-1:0] want,
                                     input logic [DATA_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      span_item_type exp_item;

      if (!reset && rsp_valid) begin
         if (pending_spans.size() == 0) begin
            $display("%0t: unexpected transaction: expected none, actual kind %0d page %0d",
                     $time, rsp_kind, rsp_page_index);
            errors++;
         end else begin
            exp_item = pending_spans.pop_front();
            errors += field_diff("kind", exp_item.kind, rsp_kind);
            errors += field_diff("page_index", exp_item.page, rsp_page_index);
            errors += field_diff("span_start", exp_item.first_col, rsp_span_start);
            errors += field_diff("span_end", exp_item.last_col, rsp_span_end);
            errors += field_diff("data_word", exp_item.data, rsp_data_word);
            errors += field_diff("byte_count", exp_item.count, rsp_byte_count);
            errors += field_diff("last", exp_item.last, rsp_last);
         end
      end
   end

   // freshly reset stores match, so nothing to emit
   task automatic test_empty_render();
      send_cmd(OP_RENDER, '0, '0, '0, 3'd0);
      send_cmd(OP_RENDER, '1, '1, '1, 3'd7);
   endtask

   task automatic test_paint_edges();
      send_cmd(OP_PAINT, 7'd0, 6'd0, FILL_SET, '0);
      send_cmd(OP_PAINT, 7'd127, 6'd63, FILL_SET, '0);
      send_cmd(OP_PAINT, 7'd127, 6'd63, 8'hFE, '1);
      send_cmd(OP_PAINT, 7'd127, 6'd63, FILL_SET, '0);
      send_cmd(OP_PAINT, 7'd9, 6'd7, FILL_SET, '0);
      send_cmd(OP_RENDER, '0, '0, '0, 3'd0);
      send_cmd(OP_RENDER, '0, '0, '0, 3'd7);
      send_cmd(OP_RENDER, '0, '0, '0, 3'd7);
   endtask

   task automatic test_unused_opcode();
      send_cmd(OP_UNUSED, '1, '1, FILL_SET, '1);
      send_cmd(OP_UNUSED, '0, '0, 8'h00, '0);
      send_cmd(OP_RENDER, '0, '0, '0, 3'd1);
   endtask

   task automatic test_full_frame();
      send_cmd(OP_CLEAR, '0, '0, FILL_SET, '0);
      send_cmd(OP_RENDER, '0, '0, '0, 3'd3);
      send_cmd(OP_PAINT, 7'd64, 6'd24, 8'h00, '0);
      send_cmd(OP_RENDER, '0, '0, '0, 3'd3);
      send_cmd(OP_CLEAR, '0, '0, 8'h00, '0);
      send_cmd(OP_RENDER, '0, '0, '0, 3'd5);
   endtask

   // mostly paint bursts on one page followed by a render of it
   task automatic test_random_traffic();
      int                  target;
      int                  pick;
      int                  n;
      int                  spread;
      logic [PSEL_W-1:0]   page;
      logic [COLX_W-1:0]   base_col;
      logic [COLX_W-1:0]   col;
      logic [VAL_W-1:0]    val;

      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         gap_off = ($urandom_range(0, 3) == 0);
         pick    = $urandom_range(0, 99);
         if (pick < 75) begin
            page     = PSEL_W'($urandom_range(0, PAGES - 1));
            n        = $urandom_range(1, 10);
            base_col = COLX_W'($urandom_range(0, COLUMNS - 1));
            case ($urandom_range(0, 3))
               0: spread = 1;
               1: spread = 8;
               2: spread = 24;
               default: spread = COLUMNS;
            endcase
            repeat (n) begin
               col = base_col + COLX_W'($urandom_range(0, spread - 1));
               val = $urandom_range(0, 1) ? FILL_SET : 8'($urandom_range(0, 255));
               send_cmd(OP_PAINT, col, {page, 3'($urandom_range(0, 7))}, val,
                        3'($urandom_range(0, 7)));
            end
            if ($urandom_range(0, 9) == 0) page = PSEL_W'($urandom_range(0, PAGES - 1));
            send_cmd(OP_RENDER, 7'($urandom), 6'($urandom), 8'($urandom), page);
         end else if (pick < 78) begin
            send_cmd(OP_CLEAR, 7'($urandom), 6'($urandom), 8'($urandom), 3'($urandom));
            send_cmd(OP_RENDER, 7'($urandom), 6'($urandom), 8'($urandom), 3'($urandom));
         end else begin
            send_cmd(2'($urandom_range(0, 3)), 7'($urandom), 6'($urandom), 8'($urandom),
                     3'($urandom));
         end
      end
      gap_off = 0;
   endtask

   initial begin
      errors          = 0;
      items_sent      = 0;
      cycle_count     = 0;
      gap_off         = 0;
      foreach (frame_mem[i]) frame_mem[i] = '0;
      foreach (shown_mem[i]) shown_mem[i] = '0;
      reset           <= 1'b1;
      start           <= 1'b0;
      req_opcode      <= OP_PAINT;
      req_column_x    <= '0;
      req_row_y       <= '0;
      req_value       <= '0;
      req_page_select <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_render();
      test_paint_edges();
      test_unused_opcode();
      test_full_frame();
      test_random_traffic();

      start <= 1'b0;
      while (pending_spans.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/pfds_pkg.sv
hdl/pfds_front.sv
hdl/pfds_queue.sv
hdl/pfds_engine.sv
hdl/page_framebuffer_dirty_span.sv
hdl/pfds_checker.sv
verif/page_framebuffer_dirty_span_tb.sv
